>>> src/work_unit_dispatcher_assert.svh
// Assertion macros for the work unit dispatcher.
// Used by the checker; expects clk_i and rst_ni in the including scope.
`ifndef WORK_UNIT_DISPATCHER_ASSERT_SVH
`define WORK_UNIT_DISPATCHER_ASSERT_SVH
// Same-cycle implication.
`define WUD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wud assertion failed");
// Next-cycle implication.
`define WUD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wud assertion failed");
`endif

>>> src/wud_pkg.sv
// Shared constants and types for the work unit dispatcher.
// No dependencies.
package wud_pkg;

  localparam int MAX_UNITS   = 4096;
  localparam int MAX_WORKERS = 64;

  typedef enum logic [2:0] {
    ACT_GET     = 3'd0,
    ACT_DONE    = 3'd1,
    ACT_TAKEN   = 3'd2,
    ACT_SHUFFLE = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

endpackage

>>> src/work_unit_dispatcher.sv
// Work unit dispatcher top level: done/taken bitmap, slot map, walker offsets.
// Depends on wud_pkg and wud_ram.
//
//  channel | handshake                  | payload
//  in      | in_valid_i / in_stall_o    | action_i worker_i unit_i worker_count_i
//  out     | out_valid_o / out_stall_i  | found_o unit_out_o was_done_o remaining_o
//          |                            | reshuffle_request_o
//  cfg     | cfg_we_i                   | cfg_wdata_i
//
// Note/query: S_NOTE, then S_DONE; a unit out of range or an unknown action goes
// straight to S_DONE. Get next: S_OFFRD, then S_STEP, S_MAPRD and, for a non-empty
// slot, S_BITRD per slot visited; a worker without a row goes straight to S_DONE.
// Shuffle: S_DIV, S_MUL, S_FILL, S_LAY, S_DONE. After reset and every cfg write a
// clearing pass of the bitmap runs with in_stall_o high. One item is worked at a time;
// a waiting result is held in the output register while the next item is taken.
module work_unit_dispatcher #(
  parameter int MAX_UNITS   = wud_pkg::MAX_UNITS,
  parameter int MAX_WORKERS = wud_pkg::MAX_WORKERS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(MAX_UNITS+1)-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [2:0]                             action_i,
  input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] worker_i,
  input  logic [$clog2(MAX_UNITS)-1:0]           unit_i,
  input  logic [$clog2(MAX_WORKERS+1)-1:0]       worker_count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   found_o,
  output logic [$clog2(MAX_UNITS)-1:0]           unit_out_o,
  output logic                                   was_done_o,
  output logic [$clog2(MAX_UNITS+1)-1:0]         remaining_o,
  output logic                                   reshuffle_request_o
);

  localparam int UW = $clog2(MAX_UNITS);
  localparam int TW = $clog2(MAX_UNITS + 1);
  localparam int SD = MAX_UNITS + MAX_WORKERS;
  localparam int SW = $clog2(SD);
  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int RW = $clog2(MAX_WORKERS + 1);
  localparam int CW = $clog2(SW + 1);
  localparam int OD = (MAX_WORKERS > 1) ? MAX_WORKERS : 2;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_OFFRD = 12'b0000_0000_0100,
    S_STEP  = 12'b0000_0000_1000,
    S_MAPRD = 12'b0000_0001_0000,
    S_BITRD = 12'b0000_0010_0000,
    S_NOTE  = 12'b0000_0100_0000,
    S_DIV   = 12'b0000_1000_0000,
    S_MUL   = 12'b0001_0000_0000,
    S_FILL  = 12'b0010_0000_0000,
    S_LAY   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e            state_q;
  logic [TW-1:0]     total_q, done_cnt_q;
  logic [RW-1:0]     rows_q, nrows_q, ri_q, rem_q;
  logic [SW-1:0]     rw_q, st_q, off_q, x_q, base_q, nq_q, wid_q, slots_q, fill_q;
  logic [SW-1:0]     rb_q, col_q;
  logic              req_sent_q, ovr_q, pv_q;
  logic [MAX_WORKERS-1:0] off_vld_q;
  logic [UW-1:0]     clr_q, unit_q, u_q, pidx_q;
  logic [TW-1:0]     i_q;
  logic [CW-1:0]     cnt_q;
  wud_pkg::action_e  act_q;
  logic [WW-1:0]     wkr_q;
  logic              rs_found_q, rs_wd_q, rs_req_q;
  logic [UW-1:0]     rs_unit_q;
  logic              out_valid_q, found_q, was_done_q, req_q;
  logic [UW-1:0]     unit_out_q;
  logic [TW-1:0]     remaining_q;

  logic              b_we, m_we, o_we;
  logic [UW-1:0]     b_waddr, b_raddr;
  logic [1:0]        b_wdata, b_rdata;
  logic [SW-1:0]     m_waddr, m_raddr;
  logic [TW-1:0]     m_wdata, m_rdata;
  logic [WW-1:0]     o_waddr, o_raddr;
  logic [2*SW-1:0]   o_wdata, o_rdata;

  logic              accept, out_free, note_wr, out_load;
  logic [SW+1:0]     pos_w, sum_w, slot_w;
  logic [RW-1:0]     rsat_w;
  logic [RW:0]       dtry_w;
  logic [TW-1:0]     cfg_sat_w;
  wud_pkg::action_e  act_w;

  assign act_w    = wud_pkg::action_e'(action_i);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_DONE) && out_free && !cfg_we_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign rsat_w = (worker_count_i > RW'(MAX_WORKERS)) ? RW'(MAX_WORKERS) : worker_count_i;
  assign dtry_w = {rem_q, nq_q[SW-1]};

  always_comb begin
    cfg_sat_w = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cfg_sat_w = TW'(1);
    end else if (cfg_wdata_i > TW'(MAX_UNITS)) begin
      cfg_sat_w = TW'(MAX_UNITS);
    end
  end

  // slot of the current walk step: own row forward, other rows mirrored
  always_comb begin
    if (off_q >= rw_q) begin
      pos_w = {2'b00, off_q} + {2'b00, rw_q} - (SW+2)'(1) - {1'b0, x_q, 1'b0};
    end else begin
      pos_w = {2'b00, off_q};
    end
    sum_w  = pos_w + {2'b00, base_q};
    slot_w = (sum_w >= {2'b00, st_q}) ? (sum_w - {2'b00, st_q}) : sum_w;
  end

  assign note_wr = (state_q == S_NOTE) &&
                   ((act_q == wud_pkg::ACT_DONE) || (act_q == wud_pkg::ACT_TAKEN));

  always_comb begin
    b_we    = 1'b0;
    b_waddr = clr_q;
    b_wdata = 2'b00;
    b_raddr = unit_i;
    case (state_q)
      S_CLEAR: b_we = 1'b1;
      S_NOTE: begin
        b_we    = note_wr;
        b_waddr = unit_q;
        b_wdata = (act_q == wud_pkg::ACT_DONE) ? {b_rdata[1], 1'b1} : {1'b1, b_rdata[0]};
      end
      S_MAPRD: b_raddr = m_rdata[UW-1:0];
      S_LAY:   b_raddr = i_q[UW-1:0];
      default: b_raddr = unit_i;
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = fill_q;
    m_wdata = TW'(MAX_UNITS);
    m_raddr = slot_w[SW-1:0];
    case (state_q)
      S_FILL: m_we = (fill_q < slots_q);
      S_LAY: begin
        m_we    = pv_q && !b_rdata[0];
        m_waddr = rb_q + col_q;
        m_wdata = TW'(pidx_q);
      end
      default: m_we = 1'b0;
    endcase
  end

  assign o_raddr = worker_i;
  assign o_waddr = wkr_q;
  assign o_wdata = {off_q, x_q};
  assign o_we    = ((state_q == S_STEP) && (off_q >= st_q)) ||
                   ((state_q == S_BITRD) && (b_rdata == 2'b00));

  wud_ram #(.W(2), .D(MAX_UNITS)) u_bits (
    .clk_i(clk_i), .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  wud_ram #(.W(TW), .D(SD)) u_map (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  wud_ram #(.W(2*SW), .D(OD)) u_offs (
    .clk_i(clk_i), .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      total_q     <= TW'(MAX_UNITS);
      done_cnt_q  <= '0;
      rows_q      <= '0;
      rw_q        <= '0;
      st_q        <= '0;
      req_sent_q  <= 1'b0;
      off_vld_q   <= '0;
      clr_q       <= '0;
      found_q     <= 1'b0;
      unit_out_q  <= '0;
      was_done_q  <= 1'b0;
      remaining_q <= '0;
      req_q       <= 1'b0;
      act_q       <= wud_pkg::ACT_GET;
      wkr_q       <= '0;
      unit_q      <= '0;
      u_q         <= '0;
      off_q       <= '0;
      x_q         <= '0;
      base_q      <= '0;
      ovr_q       <= 1'b0;
      nrows_q     <= '0;
      nq_q        <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      wid_q       <= '0;
      slots_q     <= '0;
      fill_q      <= '0;
      i_q         <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      ri_q        <= '0;
      rb_q        <= '0;
      col_q       <= '0;
      rs_found_q  <= 1'b0;
      rs_unit_q   <= '0;
      rs_wd_q     <= 1'b0;
      rs_req_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q    <= cfg_sat_w;
        done_cnt_q <= '0;
        rows_q     <= '0;
        rw_q       <= '0;
        st_q       <= '0;
        req_sent_q <= 1'b0;
        off_vld_q  <= '0;
        clr_q      <= '0;
        state_q    <= S_CLEAR;
      end else begin
        case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + UW'(1);
            if (clr_q == UW'(MAX_UNITS - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              rs_found_q <= 1'b0;
              rs_unit_q  <= '0;
              rs_wd_q    <= 1'b0;
              rs_req_q   <= 1'b0;
              act_q      <= act_w;
              unit_q     <= unit_i;
              wkr_q      <= worker_i;
              state_q    <= S_DONE;
              case (act_w)
                wud_pkg::ACT_GET: begin
                  if ({1'b0, worker_i} < (WW+1)'(rows_q)) begin
                    base_q  <= SW'(worker_i * rw_q);
                    ovr_q   <= off_vld_q[worker_i];
                    state_q <= S_OFFRD;
                  end
                end
                wud_pkg::ACT_DONE, wud_pkg::ACT_TAKEN, wud_pkg::ACT_QUERY: begin
                  if (TW'(unit_i) < total_q) begin
                    state_q <= S_NOTE;
                  end
                end
                wud_pkg::ACT_SHUFFLE: begin
                  if (worker_count_i != '0) begin
                    nrows_q <= rsat_w;
                    nq_q    <= SW'(total_q - done_cnt_q) + SW'(rsat_w) - SW'(1);
                    rem_q   <= '0;
                    cnt_q   <= '0;
                    state_q <= S_DIV;
                  end
                end
                default: state_q <= S_DONE;
              endcase
            end
          end
          S_OFFRD: begin
            off_q   <= ovr_q ? o_rdata[2*SW-1:SW] : '0;
            x_q     <= ovr_q ? o_rdata[SW-1:0] : '0;
            state_q <= S_STEP;
          end
          S_STEP: begin
            if (off_q >= st_q) begin
              off_vld_q[wkr_q] <= 1'b1;
              state_q          <= S_DONE;
            end else begin
              if ((off_q >= rw_q) && !req_sent_q) begin
                req_sent_q <= 1'b1;
                rs_req_q   <= 1'b1;
              end
              off_q   <= off_q + SW'(1);
              x_q     <= ((x_q + SW'(1)) == rw_q) ? '0 : x_q + SW'(1);
              state_q <= S_MAPRD;
            end
          end
          S_MAPRD: begin
            u_q     <= m_rdata[UW-1:0];
            state_q <= (m_rdata >= total_q) ? S_STEP : S_BITRD;
          end
          S_BITRD: begin
            if (b_rdata != 2'b00) begin
              state_q <= S_STEP;
            end else begin
              rs_found_q       <= 1'b1;
              rs_unit_q        <= u_q;
              off_vld_q[wkr_q] <= 1'b1;
              state_q          <= S_DONE;
            end
          end
          S_NOTE: begin
            rs_wd_q <= (act_q != wud_pkg::ACT_TAKEN) && b_rdata[0];
            if ((act_q == wud_pkg::ACT_DONE) && !b_rdata[0]) begin
              done_cnt_q <= done_cnt_q + TW'(1);
            end
            state_q <= S_DONE;
          end
          S_DIV: begin
            if (dtry_w >= {1'b0, nrows_q}) begin
              rem_q <= RW'(dtry_w - {1'b0, nrows_q});
              nq_q  <= {nq_q[SW-2:0], 1'b1};
            end else begin
              rem_q <= dtry_w[RW-1:0];
              nq_q  <= {nq_q[SW-2:0], 1'b0};
            end
            cnt_q <= cnt_q + CW'(1);
            if (cnt_q == CW'(SW - 1)) begin
              state_q <= S_MUL;
            end
          end
          S_MUL: begin
            wid_q   <= nq_q;
            slots_q <= SW'(nrows_q * nq_q);
            fill_q  <= '0;
            state_q <= S_FILL;
          end
          S_FILL: begin
            if (fill_q < slots_q) begin
              fill_q <= fill_q + SW'(1);
            end else begin
              i_q     <= '0;
              pv_q    <= 1'b0;
              ri_q    <= '0;
              rb_q    <= '0;
              col_q   <= '0;
              state_q <= S_LAY;
            end
          end
          S_LAY: begin
            pv_q <= (i_q < total_q);
            if (i_q < total_q) begin
              pidx_q <= i_q[UW-1:0];
              i_q    <= i_q + TW'(1);
            end
            if (pv_q && !b_rdata[0]) begin
              if ((ri_q + RW'(1)) == nrows_q) begin
                ri_q  <= '0;
                rb_q  <= '0;
                col_q <= col_q + SW'(1);
              end else begin
                ri_q <= ri_q + RW'(1);
                rb_q <= rb_q + wid_q;
              end
            end
            if (!(i_q < total_q) && !pv_q) begin
              rows_q     <= nrows_q;
              rw_q       <= wid_q;
              st_q       <= slots_q;
              off_vld_q  <= '0;
              req_sent_q <= 1'b0;
              state_q    <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              found_q     <= rs_found_q;
              unit_out_q  <= rs_unit_q;
              was_done_q  <= rs_wd_q;
              req_q       <= rs_req_q;
              remaining_q <= total_q - done_cnt_q;
              state_q     <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = found_q;
  assign unit_out_o          = unit_out_q;
  assign was_done_o          = was_done_q;
  assign remaining_o         = remaining_q;
  assign reshuffle_request_o = req_q;

endmodule

>>> src/wud_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wud_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/wud_checker.sv
// Port-level checker for the work unit dispatcher, bound to the top level.
// Depends on wud_pkg and work_unit_dispatcher_assert.svh.
`include "work_unit_dispatcher_assert.svh"

module wud_port_checker #(
  parameter int MAX_UNITS   = wud_pkg::MAX_UNITS,
  parameter int MAX_WORKERS = wud_pkg::MAX_WORKERS
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   cfg_we_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   found_o,
  input logic [$clog2(MAX_UNITS)-1:0]           unit_out_o,
  input logic                                   was_done_o,
  input logic [$clog2(MAX_UNITS+1)-1:0]         remaining_o
);

  `WUD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `WUD_ASSERT_NOW(a_found_excl, out_valid_o && found_o, !was_done_o)
  `WUD_ASSERT_NOW(a_none_zero, out_valid_o && !found_o, unit_out_o == '0)
  `WUD_ASSERT_NOW(a_rem_range, out_valid_o, remaining_o <= ($clog2(MAX_UNITS+1))'(MAX_UNITS))
  `WUD_ASSERT_NXT(a_cfg_clear, cfg_we_i, in_stall_o)

endmodule

bind work_unit_dispatcher wud_port_checker #(
  .MAX_UNITS(MAX_UNITS),
  .MAX_WORKERS(MAX_WORKERS)
) u_wud_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .cfg_we_i(cfg_we_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .found_o(found_o),
  .unit_out_o(unit_out_o),
  .was_done_o(was_done_o),
  .remaining_o(remaining_o)
);

>>> tb/sv/wud_checker.sv
// Checker for the work unit dispatcher: watches cfg, in and out transfers,
// predicts each result and compares it field by field. Depends on wud_pkg.
module wud_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [5:0]  worker_i,
  input  logic [11:0] unit_i,
  input  logic [6:0]  worker_count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        found_i,
  input  logic [11:0] unit_out_i,
  input  logic        was_done_i,
  input  logic [12:0] remaining_i,
  input  logic        reshuffle_request_i,
  output int          fails_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UNITS = wud_pkg::MAX_UNITS;
  localparam int MAX_WORKERS = wud_pkg::MAX_WORKERS;
  localparam int SLOT_DEPTH = MAX_UNITS + MAX_WORKERS;
  localparam int SLOT_EMPTY = MAX_UNITS;

  typedef struct packed {
    logic        found;
    logic [11:0] unit_out;
    logic        was_done;
    logic [12:0] remaining;
    logic        req;
  } grant_t;

  grant_t grant_q[$];
  bit done_map[MAX_UNITS];
  bit taken_map[MAX_UNITS];
  int slot_map[SLOT_DEPTH];
  int walk_pos[MAX_WORKERS];
  int job_units, rows, width, slots, done_cnt;
  bit req_sent;

  assign pending_o = grant_q.size();

  function automatic void new_job(input int units);
    job_units = units;
    foreach (done_map[i]) begin
      done_map[i] = 0;
      taken_map[i] = 0;
    end
    foreach (walk_pos[i]) walk_pos[i] = 0;
    rows = 0; width = 0; slots = 0; done_cnt = 0; req_sent = 0;
  endfunction

  function automatic void lay_out(input int r);
    int left, k, p;
    left = job_units - done_cnt;
    width = (left + r - 1) / r;
    slots = r * width;
    for (int i = 0; i < slots && i < SLOT_DEPTH; i++) slot_map[i] = SLOT_EMPTY;
    k = 0;
    for (int i = 0; i < job_units; i++) begin
      if (!done_map[i]) begin
        p = (k % r) * width + k / r;
        if (p < SLOT_DEPTH) slot_map[p] = i;
        k++;
      end
    end
    rows = r;
    foreach (walk_pos[i]) walk_pos[i] = 0;
    req_sent = 0;
  endfunction

  function automatic grant_t dispatch(input logic [2:0] act, input int w, input int u,
                                      input int wc);
    grant_t g;
    int off, pos, slot, v;
    bit in_rng;
    g = '0;
    in_rng = u < job_units;
    case (act)
      wud_pkg::ACT_GET: begin
        if (w < rows) begin
          while (walk_pos[w] < slots) begin
            off = walk_pos[w];
            pos = off;
            if (off >= width) begin
              pos = (off / width) * width + (width - (off % width) - 1);
              if (!req_sent) begin
                req_sent = 1;
                g.req = 1;
              end
            end
            slot = (w * width + pos) % slots;
            walk_pos[w] = off + 1;
            if (slot >= SLOT_DEPTH) continue;
            v = slot_map[slot];
            if (v >= job_units) continue;
            if (done_map[v] || taken_map[v]) continue;
            g.found = 1;
            g.unit_out = 12'(v);
            break;
          end
        end
      end
      wud_pkg::ACT_DONE: begin
        if (in_rng) begin
          g.was_done = done_map[u];
          if (!done_map[u]) begin
            done_map[u] = 1;
            done_cnt++;
          end
        end
      end
      wud_pkg::ACT_TAKEN: if (in_rng) taken_map[u] = 1;
      wud_pkg::ACT_SHUFFLE: if (wc != 0) lay_out(wc > MAX_WORKERS ? MAX_WORKERS : wc);
      wud_pkg::ACT_QUERY: if (in_rng) g.was_done = done_map[u];
      default: ;
    endcase
    g.remaining = 13'(job_units - done_cnt);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want, got;
    int w;
    if (!rst_ni) begin
      new_job(MAX_UNITS);
      grant_q.delete();
      fails_o <= 0;
    end else begin
      if (cfg_we_i) begin
        w = int'(cfg_wdata_i);
        new_job(w < 1 ? 1 : (w > MAX_UNITS ? MAX_UNITS : w));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{found_i, unit_out_i, was_done_i, remaining_i, reshuffle_request_i};
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $realtime, got);
          fails_o <= fails_o + 1;
        end else begin
          want = grant_q.pop_front();
          if (want != got) begin
            if (want.found != got.found)
              $display("%0t: found exp %0d got %0d", $realtime, want.found, got.found);
            if (want.unit_out != got.unit_out)
              $display("%0t: unit_out exp %0d got %0d", $realtime, want.unit_out,
                       got.unit_out);
            if (want.was_done != got.was_done)
              $display("%0t: was_done exp %0d got %0d", $realtime, want.was_done,
                       got.was_done);
            if (want.remaining != got.remaining)
              $display("%0t: remaining exp %0d got %0d", $realtime, want.remaining,
                       got.remaining);
            if (want.req != got.req)
              $display("%0t: reshuffle_request exp %0d got %0d", $realtime, want.req,
                       got.req);
            fails_o <= fails_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        grant_q.push_back(dispatch(action_i, int'(worker_i), int'(unit_i),
                                   int'(worker_count_i)));
    end
  end
endmodule

>>> tb/sv/tb.sv
// Testbench top for work_unit_dispatcher: clock, reset, stimulus and verdict.
// Depends on wud_pkg, work_unit_dispatcher and wud_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UNITS = wud_pkg::MAX_UNITS;
  localparam int MAX_WORKERS = wud_pkg::MAX_WORKERS;
  localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;
  localparam longint CYCLE_LIMIT = 100_000_000;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we = 0;
  logic [12:0] cfg_wdata = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [2:0] action = wud_pkg::ACT_GET;
  logic [5:0] worker = '0;
  logic [11:0] unit = '0;
  logic [6:0] worker_count = '0;
  logic found, was_done, req;
  logic [11:0] unit_out;
  logic [12:0] remaining;
  int fails, pending, units, rows;
  bit calm;
  longint cycles = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  work_unit_dispatcher DUT (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(action),
    .worker_i(worker), .unit_i(unit), .worker_count_i(worker_count),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .found_o(found),
    .unit_out_o(unit_out), .was_done_o(was_done), .remaining_o(remaining),
    .reshuffle_request_o(req)
  );

  wud_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .worker_i(worker), .unit_i(unit), .worker_count_i(worker_count),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .found_i(found),
    .unit_out_i(unit_out), .was_done_i(was_done), .remaining_i(remaining),
    .reshuffle_request_i(req), .fails_o(fails), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 36);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(input logic [2:0] a, input int w, input int u, input int wc);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    action <= a;
    worker <= 6'(w);
    unit <= 12'(u);
    worker_count <= 7'(wc);
    in_valid <= 1;
    do @(posedge clk_i); while (in_stall);
    if (a == wud_pkg::ACT_SHUFFLE && wc != 0) rows = wc > MAX_WORKERS ? MAX_WORKERS : wc;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_units(input int v);
    cfg_we <= 1;
    cfg_wdata <= 13'(v);
    @(posedge clk_i);
    cfg_we <= 0;
    units = v < 1 ? 1 : (v > MAX_UNITS ? MAX_UNITS : v);
    rows = 0;
  endtask

  function automatic int pick_unit();
    if ($urandom_range(9) == 0) return $urandom_range(4095);
    return $urandom_range(units - 1);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send(wud_pkg::ACT_GET, (rows == 0 || $urandom_range(9) == 0) ? $urandom_range(63)
                             : $urandom_range(rows - 1), 0, 0);
    else if (r < 65) send(wud_pkg::ACT_DONE, 0, pick_unit(), 0);
    else if (r < 75) send(wud_pkg::ACT_TAKEN, 0, pick_unit(), 0);
    else if (r < 85) send(wud_pkg::ACT_QUERY, 0, pick_unit(), 0);
    else if (r < 95)
      send(wud_pkg::ACT_SHUFFLE, 0, 0, $urandom_range(3) == 0 ? $urandom_range(127)
                                                              : $urandom_range(1, 8));
    else send(3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI)), $urandom_range(63),
              $urandom_range(4095), $urandom_range(127));
  endtask

  initial begin
    int v;
    units = MAX_UNITS;
    rows = 0;
    calm = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(wud_pkg::ACT_QUERY, 0, 4095, 0);
    send(wud_pkg::ACT_GET, 0, 0, 0);
    send(wud_pkg::ACT_DONE, 0, 0, 0);
    send(wud_pkg::ACT_DONE, 0, 4095, 0);
    send(wud_pkg::ACT_DONE, 0, 4095, 0);
    send(wud_pkg::ACT_TAKEN, 0, 5, 0);
    send(wud_pkg::ACT_QUERY, 0, 4095, 0);
    send(wud_pkg::ACT_SHUFFLE, 0, 0, 0);
    send(wud_pkg::ACT_SHUFFLE, 0, 0, 127);
    send(wud_pkg::ACT_GET, 0, 0, 0);
    send(wud_pkg::ACT_GET, 63, 0, 0);
    send(wud_pkg::ACT_GET, 63, 0, 0);
    send(ACT_UNKNOWN_LO, 63, 4095, 127);
    send(ACT_UNKNOWN_HI, 0, 0, 0);
    send(wud_pkg::ACT_SHUFFLE, 0, 0, 1);
    send(wud_pkg::ACT_GET, 1, 0, 0);
    drain();
    set_units(3);
    send(wud_pkg::ACT_SHUFFLE, 0, 0, 2);
    repeat (6) send(wud_pkg::ACT_GET, 0, 0, 0);
    send(wud_pkg::ACT_GET, 1, 0, 0);
    send(wud_pkg::ACT_QUERY, 0, 3, 0);
    send(wud_pkg::ACT_DONE, 0, 3, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: v = 0;
        1: v = 8191;
        2: v = 1;
        3: v = 4096;
        default: v = $urandom_range(2, 96);
      endcase
      calm = (ph == 5);
      set_units(v);
      send(wud_pkg::ACT_SHUFFLE, 0, 0, $urandom_range(1, 8));
      repeat (100) random_item();
      drain();
    end

    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
